[src/sts_pkg.sv]
package sts_pkg;

    // field and register widths
    localparam int RATE_W     = 20;
    localparam int FREQ_W     = 20;
    localparam int COUNT_W    = 24;
    localparam int POS_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    // register values after reset
    localparam logic [FREQ_W-1:0]  RST_TONE_FREQ    = 20'd440;
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE  = 20'd48000;
    localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 24'd48000;

    localparam int PHASE_FRACTION_BITS_DEF = 16;

    // wav header
    localparam int unsigned HDR_LEN    = 44;
    localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT    = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
    localparam logic [31:0] RIFF_BASE  = 32'd36;
    localparam logic [31:0] FMT_LEN    = 32'd16;
    localparam logic [31:0] FMT_PCM_1CH = 32'h0001_0001;
    localparam logic [31:0] FMT_ALIGN  = 32'h0010_0002;

    // sine polynomial, q30 coefficients
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172273;
    localparam logic [31:0] AMP_SCALE = 32'd32767;
    localparam logic [15:0] MAG_MAX   = 16'd16383;

    typedef struct packed {
        logic restart;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_header;
        logic       last_byte;
        logic       past_end;
    } t_rsp;

endpackage

[src/sts_req_if.sv]
interface sts_req_if;
    logic        valid;
    logic        ready;
    sts_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/sts_rsp_if.sv]
interface sts_rsp_if;
    logic        valid;
    logic        ready;
    sts_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/sine_tone_wav_stream.sv]
// channel   dir  handshake          payload
// i_req     in   valid / ready      restart
// o_rsp     out  valid / ready      out_byte, in_header, last_byte, past_end
// i_cfg     in   i_cfg_we (no wait) i_cfg_idx, i_cfg_data
//
// header and past-end bytes: evaluated, then loaded into the output register
// odd sample byte: phase step through the bit-serial divider
// even sample byte: bounded by the one-bit-per-cycle divider and seven
//   4-bit-digit multiplies of the sine
// synchronous active-low reset; a finished byte waits in the output register
//   while the next request is taken, and the block stalls only in its last state
module sine_tone_wav_stream #(
    parameter int PHASE_FRACTION_BITS = sts_pkg::PHASE_FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sts_req_if.sink                        i_req,
    sts_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int F      = PHASE_FRACTION_BITS;
    localparam int RW     = sts_pkg::RATE_W;
    localparam int PW     = sts_pkg::POS_W;
    localparam int DVD_W  = RW + F;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam logic [F-2:0] QUARTER = {1'b1, {(F-2){1'b0}}};

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ZSET = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_MST  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // multiply steps of the sine polynomial
    localparam logic [2:0] STEP_Z2    = 3'd0;
    localparam logic [2:0] STEP_C7    = 3'd1;
    localparam logic [2:0] STEP_C5    = 3'd2;
    localparam logic [2:0] STEP_C3    = 3'd3;
    localparam logic [2:0] STEP_C1    = 3'd4;
    localparam logic [2:0] STEP_Z     = 3'd5;
    localparam logic [2:0] STEP_SCALE = 3'd6;

    // header word indexes
    localparam logic [3:0] W_RIFF  = 4'd0;
    localparam logic [3:0] W_SIZE  = 4'd1;
    localparam logic [3:0] W_WAVE  = 4'd2;
    localparam logic [3:0] W_FMT   = 4'd3;
    localparam logic [3:0] W_FLEN  = 4'd4;
    localparam logic [3:0] W_PCM   = 4'd5;
    localparam logic [3:0] W_RATE  = 4'd6;
    localparam logic [3:0] W_BRATE = 4'd7;
    localparam logic [3:0] W_ALIGN = 4'd8;
    localparam logic [3:0] W_DATA  = 4'd9;

    // control state
    logic [2:0]                  r_st;
    logic                        r_ov;
    logic [DCNT_W-1:0]           r_dcnt;
    logic [2:0]                  r_mcnt;
    logic [2:0]                  r_step;
    logic                        r_mode;    // divider: 1 = phase step, 0 = fraction
    logic [sts_pkg::FREQ_W-1:0]  r_tone;
    logic [RW-1:0]               r_rate;
    logic [sts_pkg::COUNT_W-1:0] r_count;
    logic [PW-1:0]               r_pos;
    logic [RW-1:0]               r_phase;
    logic [7:0]                  r_pend;

    // datapath
    sts_pkg::t_rsp r_res;
    sts_pkg::t_rsp r_out;
    logic [DVD_W-1:0] r_dvd;
    logic [RW-1:0]    r_rem;
    logic [F-1:0]     r_quo;
    logic [31:0]      r_ma;
    logic [31:0]      r_mb;
    logic [63:0]      r_acc;
    logic [30:0]      r_z;
    logic [30:0]      r_z2;
    logic [31:0]      r_s;
    logic [1:0]       r_quad;

    logic            in_xfer;
    logic            out_load;
    logic [PW-1:0]   total;
    logic            ev_past;
    logic            ev_hdr;
    logic            ev_last;
    logic [31:0]     data_size;
    logic [31:0]     hdr_word;
    logic [7:0]      hdr_byte;
    logic [RW:0]     phase_sum;
    logic [RW:0]     dv_trial;
    logic [RW:0]     dv_diff;
    logic            dv_ge;
    logic [RW-1:0]   dv_rem;
    logic [1:0]      zq_quad;
    logic [F-2:0]    zq_r;
    logic [30:0]     zq_z;
    logic [3:0]      mul_digit;
    logic [35:0]     mul_pp;
    logic [35:0]     mul_sum;
    logic [63:0]     n_acc;
    logic [31:0]     ms_t;
    logic [31:0]     ms_s;
    logic [31:0]     ms_b;
    logic [15:0]     mag_raw;
    logic [15:0]     mag;
    logic [15:0]     smp;

    assign in_xfer   = i_req.valid && i_req.ready;
    assign out_load  = (r_st == ST_OUT) && (!r_ov || o_rsp.ready);
    assign i_req.ready = (r_st == ST_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    // stream bookkeeping
    assign data_size = {7'd0, r_count, 1'b0};
    assign total     = PW'(sts_pkg::HDR_LEN) + {1'b0, r_count, 1'b0};
    assign ev_past   = (r_pos >= total);
    assign ev_hdr    = (r_pos < PW'(sts_pkg::HDR_LEN));
    assign ev_last   = (r_pos == total - PW'(1));
    assign phase_sum = {1'b0, r_phase} + {1'b0, r_tone};

    always_comb begin
        unique case (r_pos[5:2])
            W_RIFF:  hdr_word = sts_pkg::TAG_RIFF;
            W_SIZE:  hdr_word = sts_pkg::RIFF_BASE + data_size;
            W_WAVE:  hdr_word = sts_pkg::TAG_WAVE;
            W_FMT:   hdr_word = sts_pkg::TAG_FMT;
            W_FLEN:  hdr_word = sts_pkg::FMT_LEN;
            W_PCM:   hdr_word = sts_pkg::FMT_PCM_1CH;
            W_RATE:  hdr_word = {12'd0, r_rate};
            W_BRATE: hdr_word = {11'd0, r_rate, 1'b0};
            W_ALIGN: hdr_word = sts_pkg::FMT_ALIGN;
            W_DATA:  hdr_word = sts_pkg::TAG_DATA;
            default: hdr_word = data_size;
        endcase
    end

    // little-endian byte pick
    always_comb begin
        case (r_pos[1:0])
            2'd0:    hdr_byte = hdr_word[7:0];
            2'd1:    hdr_byte = hdr_word[15:8];
            2'd2:    hdr_byte = hdr_word[23:16];
            default: hdr_byte = hdr_word[31:24];
        endcase
    end

    // restoring divider, one dividend bit per cycle
    assign dv_trial = {r_rem, r_dvd[DVD_W-1]};
    assign dv_diff  = dv_trial - {1'b0, r_rate};
    assign dv_ge    = (dv_trial >= {1'b0, r_rate});
    assign dv_rem   = dv_ge ? dv_diff[RW-1:0] : dv_trial[RW-1:0];

    // quadrant fold, fraction to q30 angle
    assign zq_quad = r_quo[F-1:F-2];
    assign zq_r    = zq_quad[0] ? (QUARTER - {1'b0, r_quo[F-3:0]})
                                : {1'b0, r_quo[F-3:0]};
    assign zq_z    = {zq_r, {(32-F){1'b0}}};

    // shift-add multiplier, one 4-bit digit of the multiplier per cycle
    assign mul_digit = r_mb[3:0];
    assign mul_pp    = 36'(r_ma) * 36'(mul_digit);
    assign mul_sum   = {4'd0, r_acc[63:32]} + mul_pp;
    assign n_acc     = {mul_sum, r_acc[31:4]};

    // horner step on the finished product
    assign ms_t = r_acc[61:30];
    always_comb begin
        unique case (r_step)
            STEP_Z2: begin
                ms_s = sts_pkg::SIN_C9;
                ms_b = {1'b0, ms_t[30:0]};
            end
            STEP_C7: begin
                ms_s = sts_pkg::SIN_C7 - ms_t;
                ms_b = {1'b0, r_z2};
            end
            STEP_C5: begin
                ms_s = sts_pkg::SIN_C5 - ms_t;
                ms_b = {1'b0, r_z2};
            end
            STEP_C3: begin
                ms_s = sts_pkg::SIN_C3 - ms_t;
                ms_b = {1'b0, r_z2};
            end
            STEP_C1: begin
                ms_s = sts_pkg::SIN_C1 - ms_t;
                ms_b = {1'b0, r_z};
            end
            STEP_Z: begin
                ms_s = ms_t;
                ms_b = sts_pkg::AMP_SCALE;
            end
            default: begin
                ms_s = r_s;
                ms_b = sts_pkg::AMP_SCALE;
            end
        endcase
    end

    // half-scale magnitude, clamped, then sign from the lower half-turn
    assign mag_raw = r_acc[46:31];
    assign mag     = (mag_raw > sts_pkg::MAG_MAX) ? sts_pkg::MAG_MAX : mag_raw;
    assign smp     = r_quad[1] ? (16'd0 - mag) : mag;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_ov    <= 1'b0;
            r_dcnt  <= '0;
            r_mcnt  <= '0;
            r_step  <= STEP_Z2;
            r_mode  <= 1'b0;
            r_tone  <= sts_pkg::RST_TONE_FREQ;
            r_rate  <= sts_pkg::RST_SAMPLE_RATE;
            r_count <= sts_pkg::RST_SAMPLE_COUNT;
            r_pos   <= '0;
            r_phase <= '0;
            r_pend  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sts_pkg::CFG_TONE_FREQ:    r_tone  <= i_cfg_data[sts_pkg::FREQ_W-1:0];
                    sts_pkg::CFG_SAMPLE_RATE:  r_rate  <= i_cfg_data[RW-1:0];
                    sts_pkg::CFG_SAMPLE_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_req.data.restart) begin
                            r_pos   <= '0;
                            r_phase <= '0;
                            r_pend  <= '0;
                        end
                        r_st <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (ev_past) begin
                        r_st <= ST_OUT;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                        if (ev_hdr) begin
                            r_st <= ST_OUT;
                        end else if (r_rate == '0) begin
                            // no rate: silent samples, phase pinned at zero
                            if (!r_pos[0]) begin
                                r_pend <= '0;
                            end else begin
                                r_phase <= '0;
                            end
                            r_st <= ST_OUT;
                        end else begin
                            r_mode <= r_pos[0];
                            r_dcnt <= r_pos[0] ? DCNT_W'(RW + 1) : DCNT_W'(DVD_W);
                            r_st   <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        if (r_mode) begin
                            r_phase <= dv_rem;
                            r_st    <= ST_OUT;
                        end else begin
                            r_st <= ST_ZSET;
                        end
                    end
                end
                ST_ZSET: begin
                    r_mcnt <= '0;
                    r_step <= STEP_Z2;
                    r_st   <= ST_MUL;
                end
                ST_MUL: begin
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_mcnt == 3'd7) begin
                        r_st <= ST_MST;
                    end
                end
                ST_MST: begin
                    if (r_step == STEP_SCALE) begin
                        r_pend <= smp[15:8];
                        r_st   <= ST_OUT;
                    end else begin
                        r_mcnt <= '0;
                        r_step <= r_step + 3'd1;
                        r_st   <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end

        case (r_st)
            ST_EVAL: begin
                r_res.past_end  <= ev_past;
                r_res.in_header <= !ev_past && ev_hdr;
                r_res.last_byte <= !ev_past && ev_last;
                if (ev_past) begin
                    r_res.out_byte <= '0;
                end else if (ev_hdr) begin
                    r_res.out_byte <= hdr_byte;
                end else if (r_pos[0]) begin
                    r_res.out_byte <= r_pend;
                end else begin
                    r_res.out_byte <= '0;
                end
                r_rem <= '0;
                if (r_pos[0]) begin
                    r_dvd <= {phase_sum, {(F-1){1'b0}}};
                end else begin
                    r_dvd <= {r_phase, {F{1'b0}}};
                end
            end
            ST_DIV: begin
                r_rem <= dv_rem;
                r_quo <= {r_quo[F-2:0], dv_ge};
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
            ST_ZSET: begin
                r_quad <= zq_quad;
                r_z    <= zq_z;
                r_ma   <= {1'b0, zq_z};
                r_mb   <= {1'b0, zq_z};
                r_acc  <= '0;
            end
            ST_MUL: begin
                r_acc <= n_acc;
                r_mb  <= {4'd0, r_mb[31:4]};
            end
            ST_MST: begin
                if (r_step == STEP_SCALE) begin
                    r_res.out_byte <= smp[7:0];
                end else begin
                    if (r_step == STEP_Z2) begin
                        r_z2 <= ms_t[30:0];
                    end
                    r_s   <= ms_s;
                    r_ma  <= ms_s;
                    r_mb  <= ms_b;
                    r_acc <= '0;
                end
            end
            default: ;
        endcase
    end

    // a past-end transfer carries a zero byte and no other flag
    a_past_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.past_end |->
            o_rsp.data.out_byte == 8'd0 && !o_rsp.data.in_header && !o_rsp.data.last_byte)
        else $error("past-end byte carries data or flags");

    // divider never runs with an exhausted count
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DIV |-> r_dcnt != '0)
        else $error("divider running with zero count");

    // a taken request always starts evaluation next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_st == ST_EVAL)
        else $error("request transfer did not start evaluation");

    // a finished byte waits while the previous one is still unread
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_OUT && r_ov && !o_rsp.ready |=> r_st == ST_OUT && r_ov)
        else $error("result overwrote an unread byte");

endmodule

[tb/sv/sine_tone_wav_stream_test.sv]
`timescale 1ns / 1ps

module sine_tone_wav_stream_test;
    import sts_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int FRAC_BITS   = PHASE_FRACTION_BITS_DEF;
    localparam int RAND_ITEMS  = 340;
    // even sample bytes run the divider and the sine multiplies, so the tail is generous
    localparam int TAIL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_PHASE  = 7;
    localparam int N_EXTREME   = 6;

    // directed stimulus rows: a request (possibly repeated) or a register write
    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   restart;
        logic [7:0]             reps;
        logic                   pinned;
        t_rsp                   want;
    } t_stim_row;

    localparam t_rsp NO_PIN       = '0;
    localparam t_rsp PAST_END_RSP = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam int   N_DIRECTED   = 27;

    // pinned rows carry the expected result: header bytes read straight off the header layout, or past-end
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // first bytes after reset, then a restart inside the header
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h52, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h49, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b1, 8'd1,  1'b1, '{8'h52, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h49, 1'b1, 1'b0, 1'b0}},
        // zero samples: header only, byte 43 is last, then past the end
        '{ROW_CFG, CFG_SAMPLE_COUNT, 24'd0,       1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b1, 8'd1,  1'b1, '{8'h52, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd3,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h24, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd38, 1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd2,  1'b1, PAST_END_RSP},
        // longest stream under a parked position: samples resume at byte 44
        '{ROW_CFG, CFG_SAMPLE_COUNT, 24'hFFFFFF,  1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd4,  1'b0, NO_PIN},
        // rate below the running phase: stale fraction wraps
        '{ROW_CFG, CFG_SAMPLE_RATE,  24'd100,     1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd2,  1'b0, NO_PIN},
        // zero rate: silence and phase held at zero
        '{ROW_CFG, CFG_SAMPLE_RATE,  24'd0,       1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd4,  1'b0, NO_PIN},
        // top frequency far above the rate
        '{ROW_CFG, CFG_TONE_FREQ,    24'hFFFFF,   1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_CFG, CFG_SAMPLE_RATE,  24'd1000,    1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd6,  1'b0, NO_PIN},
        '{ROW_CFG, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd0,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd2,  1'b0, NO_PIN},
        // riff size of the longest stream: 36 + 2 * 0xffffff = 0x02000022
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b1, 8'd1,  1'b1, '{8'h52, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd3,  1'b0, NO_PIN},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h22, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd2,  1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_TONE_FREQ,    24'd0,       1'b0, 8'd1,  1'b1, '{8'h02, 1'b1, 1'b0, 1'b0}}
    };

    // register settings of the first random phases: corners of each register and typical values
    localparam int unsigned EXT_FREQ  [N_EXTREME] = '{0, 20'hFFFFF, 20'hFFFFF, 440, 1, 12345};
    localparam int unsigned EXT_RATE  [N_EXTREME] = '{1, 20'hFFFFF, 1, 0, 20'hFFFFF, 48000};
    localparam int unsigned EXT_COUNT [N_EXTREME] = '{3, 5, 4, 6, 8, 0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sts_req_if req_if ();
    sts_rsp_if rsp_if ();

    // typed expectation travelling with the request, taken at its transfer
    logic req_pinned;
    t_rsp req_pinned_rsp;
    // no idling on either side while set
    logic calm;

    // predictor copy of registers and stream state
    logic [FREQ_W-1:0]  reg_freq;
    logic [RATE_W-1:0]  reg_rate;
    logic [COUNT_W-1:0] reg_count;
    logic [POS_W-1:0]   strm_pos;
    logic [RATE_W-1:0]  strm_phase;
    logic [7:0]         strm_high_byte;

    t_rsp wav_bytes_due [$];

    int cycles;
    int mismatches;
    int reqs_sent;
    int restarts_sent;
    int cfg_writes;
    int n_header;
    int n_sample;
    int n_past_end;
    int n_last;

    sine_tone_wav_stream #(
        .PHASE_FRACTION_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] wav_header_word(input logic [3:0] word_idx);
        logic [31:0] data_size;
        data_size = {7'd0, reg_count, 1'b0};
        case (word_idx)
            4'd0: wav_header_word = TAG_RIFF;
            4'd1: wav_header_word = RIFF_BASE + data_size;
            4'd2: wav_header_word = TAG_WAVE;
            4'd3: wav_header_word = TAG_FMT;
            4'd4: wav_header_word = FMT_LEN;
            4'd5: wav_header_word = FMT_PCM_1CH;
            4'd6: wav_header_word = {12'd0, reg_rate};
            4'd7: wav_header_word = {11'd0, reg_rate, 1'b0};
            4'd8: wav_header_word = FMT_ALIGN;
            4'd9: wav_header_word = TAG_DATA;
            default: wav_header_word = data_size;
        endcase
    endfunction

    // half-scale sine of the current phase, degree-9 polynomial in q30
    function automatic logic [15:0] sine_sample();
        logic [63:0] frac;
        logic [63:0] quarter;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        if (reg_rate == '0) begin
            sine_sample = 16'd0;
        end else begin
            quarter = 64'd1 << (FRAC_BITS - 2);
            frac = ({44'd0, strm_phase} << FRAC_BITS) / {44'd0, reg_rate};
            frac = frac & ((64'd1 << FRAC_BITS) - 64'd1);
            quad = frac[FRAC_BITS-1 -: 2];
            r = frac & (quarter - 64'd1);
            // falling quarters mirror the angle
            if (quad[0]) begin
                r = quarter - r;
            end
            z  = r << (32 - FRAC_BITS);
            z2 = (z * z) >> 30;
            s  = 64'(SIN_C7) - ((64'(SIN_C9) * z2) >> 30);
            s  = 64'(SIN_C5) - ((s * z2) >> 30);
            s  = 64'(SIN_C3) - ((s * z2) >> 30);
            s  = 64'(SIN_C1) - ((s * z2) >> 30);
            s  = (s * z) >> 30;
            mag = (s * 64'(AMP_SCALE)) >> 31;
            if (mag > 64'(MAG_MAX)) begin
                mag = 64'(MAG_MAX);
            end
            // lower half of the turn is negative
            if (quad[1]) begin
                sine_sample = 16'd0 - mag[15:0];
            end else begin
                sine_sample = mag[15:0];
            end
        end
    endfunction

    task automatic next_wav_byte(input logic restart, output t_rsp rsp);
        logic [31:0] total;
        logic [31:0] pos;
        logic [31:0] word;
        logic [15:0] smp;
        logic [20:0] phase_sum;
        total = HDR_LEN + {7'd0, reg_count, 1'b0};
        if (restart) begin
            strm_pos       = '0;
            strm_phase     = '0;
            strm_high_byte = '0;
        end
        pos = {6'd0, strm_pos};
        rsp = '0;
        if (pos >= total) begin
            // parked: position holds
            rsp.past_end = 1'b1;
        end else begin
            if (pos < HDR_LEN) begin
                word = wav_header_word(pos[5:2]);
                rsp.out_byte  = word[{pos[1:0], 3'b000} +: 8];
                rsp.in_header = 1'b1;
            end else if (!pos[0]) begin
                // low byte first, high byte kept for the next request
                smp = sine_sample();
                rsp.out_byte   = smp[7:0];
                strm_high_byte = smp[15:8];
            end else begin
                rsp.out_byte = strm_high_byte;
                if (reg_rate == '0) begin
                    strm_phase = '0;
                end else begin
                    phase_sum  = {1'b0, strm_phase} + {1'b0, reg_freq};
                    strm_phase = RATE_W'(phase_sum % {1'b0, reg_rate});
                end
            end
            rsp.last_byte = (pos == total - 32'd1);
            strm_pos = pos[POS_W-1:0] + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- monitor

    // predicts on request transfers, checks on result transfers
    always @(posedge i_clk) begin
        t_rsp due;
        t_rsp got;
        if (!i_rst_n) begin
            reg_freq       = RST_TONE_FREQ;
            reg_rate       = RST_SAMPLE_RATE;
            reg_count      = RST_SAMPLE_COUNT;
            strm_pos       = '0;
            strm_phase     = '0;
            strm_high_byte = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TONE_FREQ:    reg_freq  = i_cfg_data[FREQ_W-1:0];
                    CFG_SAMPLE_RATE:  reg_rate  = i_cfg_data[RATE_W-1:0];
                    CFG_SAMPLE_COUNT: reg_count = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                next_wav_byte(req_if.data.restart, due);
                if (req_pinned) begin
                    due = req_pinned_rsp;
                end
                wav_bytes_due.push_back(due);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (wav_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing due", got.out_byte));
                end else begin
                    due = wav_bytes_due.pop_front();
                    if (got.out_byte !== due.out_byte)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  got.out_byte, due.out_byte));
                    if (got.in_header !== due.in_header)
                        report_mismatch($sformatf("in_header %b, want %b",
                                                  got.in_header, due.in_header));
                    if (got.last_byte !== due.last_byte)
                        report_mismatch($sformatf("last_byte %b, want %b",
                                                  got.last_byte, due.last_byte));
                    if (got.past_end !== due.past_end)
                        report_mismatch($sformatf("past_end %b, want %b",
                                                  got.past_end, due.past_end));
                    if (due.past_end)
                        n_past_end++;
                    else if (due.in_header)
                        n_header++;
                    else
                        n_sample++;
                    if (due.last_byte)
                        n_last++;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 15);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d bytes still due",
                     cycles, wav_bytes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driver

    task automatic send_req(input logic restart, input logic pinned, input t_rsp pinned_rsp);
        while (!calm && $urandom_range(99) < 15) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.data.restart <= restart;
        req_pinned          <= pinned;
        req_pinned_rsp      <= pinned_rsp;
        do @(posedge i_clk); while (!req_if.ready);
        reqs_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // sender holds off until every due byte has come back
    task automatic wait_all_bytes();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (wav_bytes_due.size() != 0);
        @(posedge i_clk);
    endtask

    // caller lowers the write enable after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    initial begin
        int          rand_items;
        int          n_items;
        logic        fresh;
        logic        restart;
        logic [19:0] freq;
        logic [19:0] rate;
        logic [23:0] count;
        logic        wr_freq;
        logic        wr_rate;
        logic        wr_count;

        req_if.valid   <= 1'b0;
        req_if.data    <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_TONE_FREQ;
        i_cfg_data     <= '0;
        req_pinned     <= 1'b0;
        req_pinned_rsp <= '0;
        calm           <= 1'b0;
        reqs_sent      = 0;
        restarts_sent  = 0;
        cfg_writes     = 0;
        rand_items     = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                wait_all_bytes();
                write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].reg_val);
                i_cfg_we <= 1'b0;
            end else begin
                for (int k = 0; k < DIRECTED_ROWS[i].reps; k++) begin
                    send_req(DIRECTED_ROWS[i].restart, DIRECTED_ROWS[i].pinned,
                             DIRECTED_ROWS[i].want);
                end
            end
        end

        // random phases: short streams played mostly start to end, so
        // header, samples, last byte and past-end come up in most phases
        for (int ph = 0; rand_items < RAND_ITEMS; ph++) begin
            wait_all_bytes();
            calm <= (ph == CALM_PHASE);
            if (ph < N_EXTREME) begin
                freq     = 20'(EXT_FREQ[ph]);
                rate     = 20'(EXT_RATE[ph]);
                count    = 24'(EXT_COUNT[ph]);
                wr_freq  = 1'b1;
                wr_rate  = 1'b1;
                wr_count = 1'b1;
            end else begin
                freq  = ($urandom_range(1) != 0) ? 20'($urandom) : 20'($urandom_range(2000));
                case ($urandom_range(15))
                    0:             rate = '0;
                    1, 2, 3, 4, 5: rate = 20'($urandom_range(100, 1));
                    default:       rate = 20'($urandom);
                endcase
                // an occasional huge count toggles the upper bits; that stream never ends
                count    = ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(20));
                wr_freq  = ($urandom_range(9) < 7);
                wr_rate  = ($urandom_range(9) < 7);
                wr_count = ($urandom_range(9) < 7);
            end
            if (wr_freq)
                write_reg(CFG_TONE_FREQ, {4'd0, freq});
            if (wr_rate)
                write_reg(CFG_SAMPLE_RATE, {4'd0, rate});
            if (wr_count)
                write_reg(CFG_SAMPLE_COUNT, count);
            i_cfg_we <= 1'b0;

            // most phases restart and run a little past the end; the rest
            // carry on from wherever the last phase left the stream
            fresh = ($urandom_range(99) < 85);
            if (fresh) begin
                n_items = int'(HDR_LEN) + 2 * int'(reg_count) + $urandom_range(6);
                if (n_items > 90 || reg_count > 24'd100)
                    n_items = 90;
            end else begin
                n_items = $urandom_range(40, 5);
            end
            for (int k = 0; k < n_items; k++) begin
                restart = (fresh && k == 0) || ($urandom_range(99) < 2);
                send_req(restart, 1'b0, NO_PIN);
                rand_items++;
            end
        end

        wait_all_bytes();
        calm <= 1'b0;
        // catch stray results after the last one due
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d requests (%0d restarts) across %0d register writes",
                 reqs_sent, restarts_sent, cfg_writes);
        $display("checked %0d header, %0d sample, %0d past-end bytes, %0d stream ends",
                 n_header, n_sample, n_past_end, n_last);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
